>>> sv/jsfe_pkg.sv
// Shared types and constants for the JSON string field extractor.
// Used by the cell, the result buffer, the top level and the checker.
// No dependencies.
`default_nettype none

package jsfe_pkg;

	localparam int BYTE_W = 8;
	localparam int KEY_W  = 64;
	localparam int LEN_W  = 4;

	// Character codes the parser reacts to.
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_KEY_CHARS  = 1'b0,
		REG_KEY_LENGTH = 1'b1
	} cfg_reg_t;

	// Parser modes.
	typedef enum logic [2:0] {
		MODE_SEARCH   = 3'd0,
		MODE_COLON    = 3'd1,
		MODE_SPACE    = 3'd2,
		MODE_VALUE    = 3'd3,
		MODE_ESCAPE   = 3'd4,
		MODE_FINISHED = 3'd5
	} mode_t;

	// One result item.
	typedef struct packed {
		logic [BYTE_W-1:0] value_byte;
		logic              byte_valid;
		logic              done_res;
		logic              found;
	} res_t;

endpackage

`default_nettype wire

>>> sv/jsfe_cell.sv
// One cell of the key-matching window: holds one recent byte and compares
// the byte entering it against its needle position. Depends on jsfe_pkg.
`default_nettype none

module jsfe_cell #(
	parameter int CELL_INDEX    = 0,
	parameter int KEY_MAX_BYTES = 8
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           load,
	input  wire                           zero,
	input  wire  [jsfe_pkg::BYTE_W-1:0]   din,
	input  wire  [jsfe_pkg::KEY_W-1:0]    key_chars,
	input  wire  [jsfe_pkg::LEN_W-1:0]    eff_len,
	output logic [jsfe_pkg::BYTE_W-1:0]   dout,
	output logic                          hit
);
	import jsfe_pkg::*;

	localparam logic [LEN_W:0] IDX = (LEN_W+1)'(CELL_INDEX);

	logic [BYTE_W-1:0] byte_q;
	logic [BYTE_W-1:0] want;
	logic [LEN_W:0]    len_ext;
	logic              active;

	// Stored byte: cleared at the end of a body, else loads the byte on din when load is set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (zero) begin
			byte_q <= '0;
		end else if (load) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

	// Needle byte for this position: quotes at both ends, key bytes reversed between.
	always_comb begin
		len_ext = {1'b0, eff_len};
		want    = CH_QUOTE;
		if (CELL_INDEX != 0 && (len_ext + 1'b1) != IDX) begin
			for (int k = 0; k < KEY_MAX_BYTES; k++) begin
				if ((LEN_W+1)'(k) + IDX == len_ext) begin
					want = key_chars[8*k +: 8];
				end
			end
		end
	end

	// Cells beyond the needle length always agree.
	assign active = (len_ext + (LEN_W+1)'(2)) > IDX;
	assign hit    = !active || (din == want);

endmodule

`default_nettype wire

>>> sv/jsfe_out_buf.sv
// Two-entry result buffer that decouples the parser from the output stream.
// Depends on jsfe_pkg.
`default_nettype none

module jsfe_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  jsfe_pkg::res_t       push_res,
	output logic                 has_room,
	output logic                 out_valid,
	input  wire                  out_ready,
	output jsfe_pkg::res_t       out_res
);
	import jsfe_pkg::*;

	res_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign has_room  = (count_q != 2'd2);
	assign out_res   = entry_q[rd_ptr_q];

	// Result storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_res;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

>>> sv/json_string_field_extractor.sv
// Top level of the JSON string field extractor: parser control, the row of
// window cells and the result buffer. Depends on jsfe_pkg, jsfe_cell, jsfe_out_buf.
//
// Takes one body byte per cycle while the result buffer has room. The key
// search runs in a row of KEY_MAX_BYTES+2 cells that shift along each byte
// accepted during the search or at a restart and compare it in place, so a
// match is known in the cycle the closing quote arrives. Results are
// registered in a two-entry buffer before they reach the output; the input
// keeps flowing while one result waits, and stalls only once both buffer
// entries are full. Write the key only between bodies.
`default_nettype none

module json_string_field_extractor #(
	parameter int KEY_MAX_BYTES = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Body stream.
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,   // [7:0] body_byte
	input  wire                          s_tlast,   // body_last
	// Result stream.
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [7:0]                   m_tdata,   // [7:0] value_byte
	output logic [1:0]                   m_tuser,   // [0] byte_valid, [1] found
	output logic                         m_tlast,   // done_res
	// Configuration writes.
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [0:0]                   cfg_index,
	input  wire  [jsfe_pkg::KEY_W-1:0]   cfg_data
);
	import jsfe_pkg::*;

	localparam int WIN_DEPTH = KEY_MAX_BYTES + 2;
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int CMP_W     = (CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1;

	logic [KEY_W-1:0]  key_chars_q;
	logic [LEN_W-1:0]  key_length_q;
	logic [LEN_W-1:0]  eff_len;
	mode_t             mode_q;
	mode_t             mode_n;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_new;
	logic [BYTE_W-1:0] cell_din  [WIN_DEPTH];
	logic [BYTE_W-1:0] cell_dout [WIN_DEPTH];
	logic [WIN_DEPTH-1:0] cell_hit;
	logic              acc;
	logic              is_ws;
	logic              restart;
	logic              shift;
	logic              clear_all;
	logic              match;
	res_t              res;
	logic              res_push;
	res_t              out_res;
	logic              has_room;

	assign acc       = s_tvalid && s_tready;
	assign s_tready  = has_room;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q  <= '0;
			key_length_q <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_CHARS:  key_chars_q  <= cfg_data;
				REG_KEY_LENGTH: key_length_q <= cfg_data[LEN_W-1:0];
				default:        key_chars_q  <= key_chars_q;
			endcase
		end
	end

	assign eff_len = (key_length_q > LEN_W'(KEY_MAX_BYTES)) ? LEN_W'(KEY_MAX_BYTES)
	                                                        : key_length_q;

	// Window control: a restart clears the row and loads the current byte.
	assign is_ws = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
	               (s_tdata == CH_CR) || (s_tdata == CH_LF);
	assign restart   = (mode_q == MODE_SPACE) && !is_ws && (s_tdata != CH_QUOTE);
	assign shift     = acc && ((mode_q == MODE_SEARCH) || restart);
	assign clear_all = acc && s_tlast;

	// Row of window cells: the head is fed by the body byte, each other cell by its neighbor.
	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_din[i] = s_tdata;
		end else begin : g_body
			assign cell_din[i] = restart ? '0 : cell_dout[i-1];
		end
		jsfe_cell #(
			.CELL_INDEX    (i),
			.KEY_MAX_BYTES (KEY_MAX_BYTES)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (shift),
			.zero      (clear_all),
			.din       (cell_din[i]),
			.key_chars (key_chars_q),
			.eff_len   (eff_len),
			.dout      (cell_dout[i]),
			.hit       (cell_hit[i])
		);
	end

	// Saturating count of bytes held in the window.
	always_comb begin
		if (restart) begin
			count_new = CNT_W'(1);
		end else if (count_q < CNT_W'(WIN_DEPTH)) begin
			count_new = count_q + 1'b1;
		end else begin
			count_new = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear_all) begin
			count_q <= '0;
		end else if (shift) begin
			count_q <= count_new;
		end
	end

	assign match = (&cell_hit) &&
	               (CMP_W'(count_new) >= (CMP_W'(eff_len) + CMP_W'(2)));

	// Next parser mode.
	always_comb begin
		mode_n = mode_q;
		case (mode_q)
			MODE_SEARCH: begin
				if (match) mode_n = MODE_COLON;
			end
			MODE_COLON: begin
				if (s_tdata == CH_COLON) mode_n = MODE_SPACE;
			end
			MODE_SPACE: begin
				if (s_tdata == CH_QUOTE) begin
					mode_n = MODE_VALUE;
				end else if (!is_ws) begin
					mode_n = match ? MODE_COLON : MODE_SEARCH;
				end
			end
			MODE_VALUE: begin
				if (s_tdata == CH_BSLASH) begin
					mode_n = MODE_ESCAPE;
				end else if (s_tdata == CH_QUOTE) begin
					mode_n = MODE_FINISHED;
				end
			end
			MODE_ESCAPE:   mode_n = MODE_VALUE;
			MODE_FINISHED: mode_n = MODE_FINISHED;
			default:       mode_n = MODE_FINISHED;
		endcase
		if (s_tlast) begin
			mode_n = MODE_SEARCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SEARCH;
		end else if (acc) begin
			mode_q <= mode_n;
		end
	end

	// Result item for the current byte.
	always_comb begin
		res.byte_valid = 1'b0;
		res.done_res   = 1'b0;
		res.found      = 1'b0;
		case (mode_q)
			MODE_VALUE: begin
				if (s_tdata == CH_QUOTE) begin
					res.done_res = 1'b1;
					res.found    = 1'b1;
				end else if (s_tdata != CH_BSLASH) begin
					res.byte_valid = 1'b1;
				end
			end
			MODE_ESCAPE: res.byte_valid = 1'b1;
			default:     res.byte_valid = 1'b0;
		endcase
		if (s_tlast && (mode_q != MODE_FINISHED)) begin
			res.done_res = 1'b1;
		end
		res.value_byte = res.byte_valid ? s_tdata : '0;
	end

	assign res_push = acc && (res.byte_valid || res.done_res);

	jsfe_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_res  (res),
		.has_room  (has_room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.value_byte;
	assign m_tuser = {out_res.found, out_res.byte_valid};
	assign m_tlast = out_res.done_res;

endmodule

`default_nettype wire

>>> sv/jsfe_checker.sv
// Port-level checks for the JSON string field extractor, bound to the top level.
// Depends on jsfe_pkg for the byte width.
`default_nettype none

module jsfe_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire  [jsfe_pkg::BYTE_W-1:0]  m_tdata,
	input wire  [1:0]                   m_tuser,
	input wire                          m_tlast
);
	import jsfe_pkg::*;

	// A stalled result item stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// A stalled result item keeps its contents.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// A found flag only comes with the end of extraction.
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("found without done");

	// An item without a value character carries a zero byte.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == {BYTE_W{1'b0}})
		else $error("nonzero byte without byte_valid");

	// The input only stalls while results wait in the buffer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule

bind json_string_field_extractor jsfe_checker u_jsfe_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for json_string_field_extractor: sends response bodies,
// predicts every value byte and done result, and checks the result stream.
// Depends on jsfe_pkg and json_string_field_extractor.

module testbench;
	import jsfe_pkg::*;

	localparam int KEY_MAX     = 8;
	localparam int WIN_DEPTH   = KEY_MAX + 2;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 120;

	typedef logic [BYTE_W-1:0] byte_t;

	logic clk = 1'b0;
	logic arst_n;

	logic              s_tvalid;
	logic              s_tready;
	byte_t             s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	byte_t             m_tdata;
	logic [1:0]        m_tuser;
	logic              m_tlast;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [0:0]        cfg_index;
	logic [KEY_W-1:0]  cfg_data;

	// Predicted parser state and register copies.
	mode_t             pmode;
	byte_t             window [WIN_DEPTH];
	int unsigned       window_fill;
	logic [KEY_W-1:0]  key_chars_m;
	logic [LEN_W-1:0]  key_len_m;

	res_t              expected_q [$];
	byte_t             body_buf [$];
	int                errors = 0;
	int                items_sent = 0;
	int                send_idle_pct;
	int                recv_idle_pct;
	logic              rx_hold_req;
	int                rx_hold_left = 0;
	int                quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	json_string_field_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Key length in use, with oversized lengths clamped to KEY_MAX.
	function automatic int unsigned key_len_eff();
		return (key_len_m > KEY_MAX) ? KEY_MAX : key_len_m;
	endfunction

	// Byte at position pos of the quoted key, n bytes long including both quotes.
	function automatic byte_t needle_byte(int unsigned pos, int unsigned n);
		if (pos == 0 || pos == n - 1)
			return CH_QUOTE;
		return key_chars_m[8*(pos-1) +: 8];
	endfunction

	function automatic void clear_window();
		foreach (window[i])
			window[i] = '0;
		window_fill = 0;
	endfunction

	// Add one byte at the end of the body being built.
	function automatic void append_byte(byte_t b);
		body_buf.insert(body_buf.size(), b);
	endfunction

	// Shift one byte into the window and tell whether it now ends in the quoted key.
	function automatic logic shift_and_match(byte_t b);
		int unsigned n;
		n = key_len_eff() + 2;
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = b;
		if (window_fill < WIN_DEPTH)
			window_fill++;
		if (window_fill < n)
			return 1'b0;
		for (int unsigned i = 0; i < n; i++)
			if (window[i] != needle_byte(n - 1 - i, n))
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the parser prediction by one body byte and queue any result it causes.
	function automatic void predict_byte(byte_t b, logic last);
		logic emit;
		logic done;
		logic found;
		logic was_finished;
		res_t r;
		emit = 1'b0;
		done = 1'b0;
		found = 1'b0;
		was_finished = (pmode == MODE_FINISHED);
		case (pmode)
			MODE_SEARCH: begin
				if (shift_and_match(b))
					pmode = MODE_COLON;
			end
			MODE_COLON: begin
				if (b == CH_COLON)
					pmode = MODE_SPACE;
			end
			MODE_SPACE: begin
				if (b == CH_QUOTE) begin
					pmode = MODE_VALUE;
				end else if (!(b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)) begin
					// Anything but blanks or a quote restarts the search at this byte.
					clear_window();
					pmode = shift_and_match(b) ? MODE_COLON : MODE_SEARCH;
				end
			end
			MODE_VALUE: begin
				if (b == CH_BSLASH) begin
					pmode = MODE_ESCAPE;
				end else if (b == CH_QUOTE) begin
					done = 1'b1;
					found = 1'b1;
					pmode = MODE_FINISHED;
				end else begin
					emit = 1'b1;
				end
			end
			MODE_ESCAPE: begin
				emit = 1'b1;
				pmode = MODE_VALUE;
			end
			default: pmode = MODE_FINISHED;
		endcase

		// The end of the body closes any open extraction and resets the parser.
		if (last) begin
			if (!was_finished && !done)
				done = 1'b1;
			pmode = MODE_SEARCH;
			clear_window();
		end

		if (emit || done) begin
			r.value_byte = emit ? b : '0;
			r.byte_valid = emit;
			r.done_res = done;
			r.found = found;
			expected_q.insert(expected_q.size(), r);
		end
	endfunction

	function automatic byte_t value_char();
		byte_t c;
		do
			c = byte_t'($urandom);
		while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic byte_t blank_char();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// Random bytes biased toward the characters the parser reacts to.
	function automatic byte_t noise_char();
		int unsigned k;
		k = $urandom_range(KEY_MAX - 1);
		case ($urandom_range(5))
			0: return CH_QUOTE;
			1: return CH_COLON;
			2: return CH_BSLASH;
			3: return key_chars_m[8*k +: 8];
			default: return byte_t'($urandom);
		endcase
	endfunction

	// Build a body holding the key and a string value, then damage it if asked.
	function automatic void build_body(logic well_formed, int unsigned value_len);
		int unsigned n;
		int unsigned open_at;
		int unsigned cut;
		byte_t c;
		body_buf.delete();
		repeat ($urandom_range(6))
			append_byte(noise_char());
		n = key_len_eff() + 2;
		for (int unsigned p = 0; p < n; p++)
			append_byte(needle_byte(p, n));
		repeat ($urandom_range(2)) begin
			do
				c = noise_char();
			while (c == CH_COLON);
			append_byte(c);
		end
		append_byte(CH_COLON);
		repeat ($urandom_range(3))
			append_byte(blank_char());
		open_at = body_buf.size();
		append_byte(CH_QUOTE);
		repeat (value_len) begin
			if ($urandom_range(7) == 0) begin
				append_byte(CH_BSLASH);
				append_byte(byte_t'($urandom));
			end else begin
				append_byte(value_char());
			end
		end
		append_byte(CH_QUOTE);
		repeat ($urandom_range(4))
			append_byte(noise_char());

		if (!well_formed) begin
			case ($urandom_range(2))
				0: begin
					// Body ends early, anywhere in the sequence.
					cut = $urandom_range(1, body_buf.size());
					while (body_buf.size() > cut)
						void'(body_buf.pop_back());
				end
				1: begin
					// Something other than a quote where the value should open.
					body_buf[open_at] = value_char();
				end
				default: begin
					body_buf.delete();
					repeat ($urandom_range(1, 30))
						append_byte(noise_char());
				end
			endcase
		end
	endfunction

	// Send one item with a random lead-in gap; entered and left at a falling edge.
	task automatic send_byte(byte_t b, logic last);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		predict_byte(b, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_body(int unsigned from, int unsigned upto);
		for (int unsigned i = from; i < upto; i++)
			send_byte(body_buf[i], i == body_buf.size() - 1);
	endtask

	// Stop sending and wait until every predicted result has arrived.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write both key registers back to back; only called with the block idle.
	task automatic write_key(logic [KEY_W-1:0] chars, logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len;
		cfg_valid <= 1'b1;
		cfg_index <= REG_KEY_CHARS;
		cfg_data <= chars;
		do
			@(posedge clk);
		while (!cfg_ready);
		key_chars_m = chars;
		@(negedge clk);
		cfg_index <= REG_KEY_LENGTH;
		cfg_data <= len_word;
		do
			@(posedge clk);
		while (!cfg_ready);
		key_len_m = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
		$display("%0t ns: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
		errors++;
	endtask

	// Empty key: the search looks for two adjacent quotes; escaped quote in the
	// value, and bytes after the closing quote are dropped, the last one too.
	task automatic test_empty_key();
		quiesce();
		write_key('0, 4'd0);
		body_buf = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, CH_BSLASH, CH_QUOTE,
			CH_QUOTE, 8'h7A};
		send_body(0, body_buf.size());
	endtask

	// Oversized key length clamps to the full window; the match lands on the last byte.
	task automatic test_key_saturation();
		quiesce();
		write_key('1, 4'hF);
		body_buf.delete();
		append_byte(CH_QUOTE);
		repeat (KEY_MAX) append_byte(8'hFF);
		append_byte(CH_QUOTE);
		send_body(0, body_buf.size());
	endtask

	// Closing quote on the last byte, then a value byte on the last byte.
	task automatic test_value_edges();
		quiesce();
		write_key('0, 4'd1);
		body_buf = '{CH_QUOTE, 8'h00, CH_QUOTE, CH_COLON, CH_CR, CH_QUOTE, CH_QUOTE};
		send_body(0, body_buf.size());
		body_buf = '{CH_QUOTE, 8'h00, CH_QUOTE, CH_COLON, CH_QUOTE, 8'h61};
		send_body(0, body_buf.size());
	endtask

	// Random bodies, mostly well formed, with a fresh key every few bodies.
	task automatic test_random_bodies(int sender_pct, int receiver_pct, int item_goal);
		int start;
		int bodies;
		logic [KEY_W-1:0] chars;
		logic [LEN_W-1:0] len;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		start = items_sent;
		bodies = 0;
		while (items_sent - start < item_goal) begin
			if (bodies % 6 == 0) begin
				if ($urandom_range(1)) begin
					chars = {$urandom, $urandom};
				end else begin
					for (int i = 0; i < KEY_MAX; i++)
						chars[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
				end
				case ($urandom_range(9))
					0: len = '0;
					1: len = LEN_W'($urandom_range(9, 15));
					default: len = LEN_W'($urandom_range(1, 8));
				endcase
				quiesce();
				write_key(chars, len);
			end
			build_body($urandom_range(3) != 0, $urandom_range(12));
			send_body(0, body_buf.size());
			bodies++;
		end
	endtask

	// Long value while the result side holds off: the buffer fills and stalls input.
	task automatic test_output_stall();
		quiesce();
		write_key(64'h65736E6F70736572, 4'd8);
		build_body(1'b1, 48);
		rx_hold_req <= 1'b1;
		send_body(0, body_buf.size());
	endtask

	// Sender pauses halfway through a body until all results are in.
	task automatic test_sender_pause();
		int unsigned half;
		build_body(1'b1, 10);
		half = body_buf.size() / 2;
		send_body(0, half);
		quiesce();
		send_body(half, body_buf.size());
	endtask

	// Result side readiness: random idling, or a long hold when one is requested.
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_req) begin
			m_tready <= 1'b0;
			rx_hold_left <= HOLD_CYCLES;
			rx_hold_req <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 8'h00, m_tdata);
			end else begin
				want = expected_q.pop_front();
				if (m_tdata !== want.value_byte)
					report_mismatch("value_byte", want.value_byte, m_tdata);
				if (m_tuser[0] !== want.byte_valid)
					report_mismatch("byte_valid", 8'(want.byte_valid), 8'(m_tuser[0]));
				if (m_tlast !== want.done_res)
					report_mismatch("done_res", 8'(want.done_res), 8'(m_tlast));
				if (m_tuser[1] !== want.found)
					report_mismatch("found", 8'(want.found), 8'(m_tuser[1]));
			end
		end
	end

	// Watchdog: too long without any item moving on any channel ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY_CHARS;
		cfg_data = '0;
		rx_hold_req = 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 55;
		pmode = MODE_SEARCH;
		clear_window();
		key_chars_m = '0;
		key_len_m = LEN_W'(1);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_key();
		test_key_saturation();
		test_value_edges();
		test_random_bodies(17, 55, 500);
		test_random_bodies(55, 17, 500);
		test_random_bodies(0, 0, 500);
		test_output_stall();
		test_sender_pause();

		quiesce();
		if (errors == 0 && expected_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
